// File: hdl/lces_pkg.sv
`timescale 1ns / 1ps
package lces_pkg;

    // Effect modes
    localparam logic [1:0] MODE_RGB_LOOP = 2'd0;
    localparam logic [1:0] MODE_FADE     = 2'd1;
    localparam logic [1:0] MODE_STROBE   = 2'd2;

    // Input opcodes
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_EFFECT_MODE    = 3'd0;
    localparam logic [2:0] REG_COLOR_RED      = 3'd1;
    localparam logic [2:0] REG_COLOR_GREEN    = 3'd2;
    localparam logic [2:0] REG_COLOR_BLUE     = 3'd3;
    localparam logic [2:0] REG_FLASH_COUNT    = 3'd4;
    localparam logic [2:0] REG_FLASH_DELAY_MS = 3'd5;
    localparam logic [2:0] REG_END_PAUSE_MS   = 3'd6;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register reset values
    localparam logic [1:0]  RST_EFFECT_MODE    = MODE_RGB_LOOP;
    localparam logic [7:0]  RST_COLOR          = 8'd255;
    localparam logic [7:0]  RST_FLASH_COUNT    = 8'd10;
    localparam logic [15:0] RST_FLASH_DELAY_MS = 16'd50;
    localparam logic [15:0] RST_END_PAUSE_MS   = 16'd1000;

    // Minimum gap of the rgb loop, must be exceeded
    localparam logic [31:0] RGB_LOOP_GAP_MS = 32'd3;

    // Phase codes: up or on, down or off, end pause
    localparam logic [1:0] PH_UP    = 2'd0;
    localparam logic [1:0] PH_DOWN  = 2'd1;
    localparam logic [1:0] PH_PAUSE = 2'd2;

    localparam logic [7:0] LEVEL_TOP = 8'd255;

    typedef struct packed {
        logic [1:0]  effect_mode;
        logic [7:0]  color_red;
        logic [7:0]  color_green;
        logic [7:0]  color_blue;
        logic [7:0]  flash_count;
        logic [15:0] flash_delay_ms;
        logic [15:0] end_pause_ms;
    } t_cfg;

    typedef struct packed {
        logic       strip_update;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } t_result;

endpackage

// File: hdl/lces_cfg.sv
`timescale 1ns / 1ps
module lces_cfg import lces_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[ADDR_W-1:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.effect_mode    <= RST_EFFECT_MODE;
            r_cfg.color_red      <= RST_COLOR;
            r_cfg.color_green    <= RST_COLOR;
            r_cfg.color_blue     <= RST_COLOR;
            r_cfg.flash_count    <= RST_FLASH_COUNT;
            r_cfg.flash_delay_ms <= RST_FLASH_DELAY_MS;
            r_cfg.end_pause_ms   <= RST_END_PAUSE_MS;
        end else if (w_wr) begin
            case (w_idx)
                REG_EFFECT_MODE:    r_cfg.effect_mode    <= pwdata[1:0];
                REG_COLOR_RED:      r_cfg.color_red      <= pwdata[7:0];
                REG_COLOR_GREEN:    r_cfg.color_green    <= pwdata[7:0];
                REG_COLOR_BLUE:     r_cfg.color_blue     <= pwdata[7:0];
                REG_FLASH_COUNT:    r_cfg.flash_count    <= pwdata[7:0];
                REG_FLASH_DELAY_MS: r_cfg.flash_delay_ms <= pwdata[15:0];
                REG_END_PAUSE_MS:   r_cfg.end_pause_ms   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_EFFECT_MODE:    prdata = {30'd0, r_cfg.effect_mode};
            REG_COLOR_RED:      prdata = {24'd0, r_cfg.color_red};
            REG_COLOR_GREEN:    prdata = {24'd0, r_cfg.color_green};
            REG_COLOR_BLUE:     prdata = {24'd0, r_cfg.color_blue};
            REG_FLASH_COUNT:    prdata = {24'd0, r_cfg.flash_count};
            REG_FLASH_DELAY_MS: prdata = {16'd0, r_cfg.flash_delay_ms};
            REG_END_PAUSE_MS:   prdata = {16'd0, r_cfg.end_pause_ms};
            default:            prdata = '0;
        endcase
    end

endmodule

// File: hdl/lces_core.sv
`timescale 1ns / 1ps
module lces_core import lces_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_fire,
    input  logic        i_opcode,
    input  logic [31:0] i_now_ms,
    output t_result     o_result
);

    logic        r_start_pending;
    logic [7:0]  r_step_counter;
    logic [7:0]  r_ramp_level;
    logic [1:0]  r_phase;
    logic [31:0] r_last_update_time;

    logic        n_start_pending;
    logic [7:0]  n_step_counter;
    logic [7:0]  n_ramp_level;
    logic [1:0]  n_phase;
    logic [31:0] n_last_update_time;

    // State after a pending restart is taken
    logic [7:0]  w_sc;
    logic [7:0]  w_rl;
    logic [1:0]  w_ph;

    // Ramp advanced by one step
    logic [7:0]  w_adv_rl;
    logic [1:0]  w_adv_ph;
    logic        w_adv_wrap;

    logic [31:0] w_elapsed;
    logic [8:0]  w_next_flash;
    logic [15:0] w_prod_r;
    logic [15:0] w_prod_g;
    logic [15:0] w_prod_b;

    assign w_sc = r_start_pending ? 8'd0 : r_step_counter;
    assign w_rl = r_start_pending ? 8'd0 : r_ramp_level;
    assign w_ph = r_start_pending ? PH_UP : r_phase;

    assign w_elapsed    = i_now_ms - r_last_update_time;
    assign w_next_flash = {1'b0, w_sc} + 9'd1;

    always_comb begin
        w_adv_wrap = 1'b0;
        if (w_ph == PH_UP) begin
            w_adv_rl = w_rl + 8'd1;
            w_adv_ph = (w_adv_rl == LEVEL_TOP) ? PH_DOWN : PH_UP;
        end else begin
            // any nonzero phase ramps down
            w_adv_rl = w_rl - 8'd1;
            w_adv_ph = w_ph;
            if (w_adv_rl == 8'd0) begin
                w_adv_ph   = PH_UP;
                w_adv_wrap = 1'b1;
            end
        end
    end

    assign w_prod_r = {8'd0, w_adv_rl} * {8'd0, i_cfg.color_red};
    assign w_prod_g = {8'd0, w_adv_rl} * {8'd0, i_cfg.color_green};
    assign w_prod_b = {8'd0, w_adv_rl} * {8'd0, i_cfg.color_blue};

    always_comb begin
        n_start_pending    = r_start_pending;
        n_step_counter     = r_step_counter;
        n_ramp_level       = r_ramp_level;
        n_phase            = r_phase;
        n_last_update_time = r_last_update_time;
        o_result           = '0;

        if (i_opcode == OP_RESTART) begin
            n_start_pending = 1'b1;
        end else begin
            case (i_cfg.effect_mode)
                MODE_RGB_LOOP: begin
                    if (w_elapsed > RGB_LOOP_GAP_MS) begin
                        n_last_update_time    = i_now_ms;
                        n_start_pending       = 1'b0;
                        o_result.strip_update = 1'b1;
                        case (w_sc)
                            8'd0:    o_result.out_red   = w_rl;
                            8'd1:    o_result.out_green = w_rl;
                            8'd2:    o_result.out_blue  = w_rl;
                            default: ;
                        endcase
                        n_ramp_level = w_adv_rl;
                        n_phase      = w_adv_ph;
                        if (w_adv_wrap) begin
                            n_step_counter = (w_sc >= 8'd2) ? 8'd0 : w_sc + 8'd1;
                        end else begin
                            n_step_counter = w_sc;
                        end
                    end
                end
                MODE_FADE: begin
                    n_start_pending       = 1'b0;
                    n_step_counter        = w_sc;
                    n_ramp_level          = w_adv_rl;
                    n_phase               = w_adv_ph;
                    o_result.strip_update = 1'b1;
                    o_result.out_red      = w_prod_r[15:8];
                    o_result.out_green    = w_prod_g[15:8];
                    o_result.out_blue     = w_prod_b[15:8];
                end
                MODE_STROBE: begin
                    n_start_pending = 1'b0;
                    n_step_counter  = w_sc;
                    n_ramp_level    = w_rl;
                    n_phase         = w_ph;
                    if ((w_elapsed > {16'd0, i_cfg.flash_delay_ms}) &&
                        (w_ph == PH_UP || w_ph == PH_DOWN)) begin
                        n_last_update_time    = i_now_ms;
                        o_result.strip_update = 1'b1;
                        if (w_ph == PH_UP) begin
                            o_result.out_red   = i_cfg.color_red;
                            o_result.out_green = i_cfg.color_green;
                            o_result.out_blue  = i_cfg.color_blue;
                            n_phase            = PH_DOWN;
                        end else if (w_next_flash < {1'b0, i_cfg.flash_count}) begin
                            n_step_counter = w_next_flash[7:0];
                            n_phase        = PH_UP;
                        end else begin
                            n_step_counter = 8'd0;
                            n_phase        = PH_PAUSE;
                        end
                    end else if ((w_elapsed > {16'd0, i_cfg.end_pause_ms}) &&
                                 !(w_ph == PH_UP || w_ph == PH_DOWN)) begin
                        n_phase = PH_UP;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pending    <= 1'b1;
            r_step_counter     <= 8'd0;
            r_ramp_level       <= 8'd0;
            r_phase            <= PH_UP;
            r_last_update_time <= 32'd0;
        end else if (i_fire) begin
            r_start_pending    <= n_start_pending;
            r_step_counter     <= n_step_counter;
            r_ramp_level       <= n_ramp_level;
            r_phase            <= n_phase;
            r_last_update_time <= n_last_update_time;
        end
    end

endmodule

// File: hdl/lces_obuf.sv
`timescale 1ns / 1ps
module lces_obuf import lces_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_space,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_stall
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    w_load;

    assign o_space = ~r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    // output register free this cycle
    assign w_load  = ~r_out_valid | ~i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid  <= r_skid_valid | i_push;
            r_skid_valid <= r_skid_valid & i_push;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= r_skid_valid ? r_skid : i_data;
            if (r_skid_valid && i_push) begin
                r_skid <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule

// File: hdl/led_color_effect_sequencer_top.sv
`timescale 1ns / 1ps
// LED color effect sequencer. Every input word is either a tick carrying the
// current free-running millisecond time or a restart, and every input word
// yields exactly one result word: a strip_update flag and one red, green,
// blue value for the whole strip (all zero when nothing new is shown). The
// mode register picks rgb channel loop, fade in and out, or strobe; a fourth
// mode code leaves the strip alone. Elapsed time wraps modulo 2^32. Rate: one
// word per clock sustained while the output is not stalled. An accepted
// word is registered, then makes one pass through the effect logic into the
// result register. A two-entry output buffer keeps accepting while
// a result waits. Registers sit on an APB-style port at byte address
// 4*index; write them only while no word is in flight.
module led_color_effect_sequencer_top import lces_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // input words
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_opcode,
    input  logic [31:0]       i_now_ms,
    // result words
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_strip_update,
    output logic [7:0]        o_out_red,
    output logic [7:0]        o_out_green,
    output logic [7:0]        o_out_blue
);

    t_cfg        w_cfg;
    t_result     w_result;
    t_result     w_out;
    logic        w_space;
    logic        w_fire;
    logic        w_in_accept;

    logic        r_in_valid;
    logic        r_in_opcode;
    logic [31:0] r_in_now;

    lces_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Process the held word whenever the output buffer has room
    assign w_fire      = r_in_valid & w_space;
    // Stall only when the held word cannot move on this cycle
    assign o_in_stall  = r_in_valid & ~w_fire;
    assign w_in_accept = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_opcode <= i_opcode;
            r_in_now    <= i_now_ms;
        end
    end

    // Effect state and the single combinational step
    lces_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_fire   (w_fire),
        .i_opcode (r_in_opcode),
        .i_now_ms (r_in_now),
        .o_result (w_result)
    );

    // Result register plus skid entry
    lces_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fire),
        .i_data  (w_result),
        .o_space (w_space),
        .o_valid (o_out_valid),
        .o_data  (w_out),
        .i_stall (i_out_stall)
    );

    assign o_strip_update = w_out.strip_update;
    assign o_out_red      = w_out.out_red;
    assign o_out_green    = w_out.out_green;
    assign o_out_blue     = w_out.out_blue;

endmodule

// File: bench/tb_led_color_effect_sequencer_top.sv
`timescale 1ns / 1ps
module tb_led_color_effect_sequencer_top;
    import lces_pkg::*;

    // Mode code with no effect; the package names only the three live modes
    localparam logic [1:0] MODE_OFF = 2'd3;

    // Channel selected by the step counter in rgb loop mode
    localparam logic [7:0] CH_RED   = 8'd0;
    localparam logic [7:0] CH_GREEN = 8'd1;
    localparam logic [7:0] CH_BLUE  = 8'd2;

    localparam t_result NO_UPDATE = '0;

    typedef enum logic {ROW_WORD, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic        op;
        logic [2:0]  reg_idx;
        logic [31:0] value;     // now_ms for a word, register value for a write
        bit          has_want;
        t_result     want;
    } t_dir_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_opcode;
    logic [31:0]       i_now_ms;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_strip_update;
    logic [7:0]        o_out_red;
    logic [7:0]        o_out_green;
    logic [7:0]        o_out_blue;

    // Shadow of the register file and of the effect state
    t_cfg        cfg;
    logic        pending;
    logic [7:0]  step_cnt;
    logic [7:0]  lvl;
    logic [1:0]  ph;
    logic [31:0] last_ms;

    t_result  strip_colors_q[$];
    t_dir_row dir_rows[$];
    int       mismatches;
    int       send_idle_pct;
    int       stall_pct;

    led_color_effect_sequencer_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_now_ms       (i_now_ms),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_strip_update (o_strip_update),
        .o_out_red      (o_out_red),
        .o_out_green    (o_out_green),
        .o_out_blue     (o_out_blue)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // Effect predictor
    // ---------------------------------------------------------------

    // Re-arm the sequence if a restart word came in
    function automatic void take_start();
        if (pending) begin
            step_cnt = 8'd0;
            lvl      = 8'd0;
            ph       = PH_UP;
            pending  = 1'b0;
        end
    endfunction

    // Advance the triangle ramp; report the moment a down ramp hits zero.
    // Any phase other than up counts as ramping down.
    function automatic bit ramp_step();
        if (ph == PH_UP) begin
            lvl = lvl + 8'd1;
            if (lvl == LEVEL_TOP)
                ph = PH_DOWN;
            return 1'b0;
        end
        lvl = lvl - 8'd1;
        if (lvl == 8'd0) begin
            ph = PH_UP;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] fade_scale(logic [7:0] color);
        logic [15:0] prod;
        prod = 16'(lvl) * 16'(color);
        return prod[15:8];
    endfunction

    function automatic t_result predict_strip(logic op, logic [31:0] now);
        t_result    res;
        logic [31:0] elapsed;
        logic [8:0]  next_cnt;
        res     = NO_UPDATE;
        elapsed = now - last_ms;
        if (op == OP_RESTART) begin
            pending = 1'b1;
            return res;
        end
        case (cfg.effect_mode)
            MODE_RGB_LOOP: begin
                if (elapsed > RGB_LOOP_GAP_MS) begin
                    last_ms = now;
                    take_start();
                    res.strip_update = 1'b1;
                    // a channel index past blue shows black
                    case (step_cnt)
                        CH_RED:   res.out_red   = lvl;
                        CH_GREEN: res.out_green = lvl;
                        CH_BLUE:  res.out_blue  = lvl;
                        default: ;
                    endcase
                    if (ramp_step())
                        step_cnt = (step_cnt >= CH_BLUE) ? CH_RED : step_cnt + 8'd1;
                end
            end
            MODE_FADE: begin
                take_start();
                void'(ramp_step());
                res = '{1'b1, fade_scale(cfg.color_red), fade_scale(cfg.color_green),
                        fade_scale(cfg.color_blue)};
            end
            MODE_STROBE: begin
                take_start();
                if (elapsed > 32'(cfg.flash_delay_ms) && ph <= PH_DOWN) begin
                    last_ms = now;
                    res.strip_update = 1'b1;
                    if (ph == PH_UP) begin
                        res = '{1'b1, cfg.color_red, cfg.color_green, cfg.color_blue};
                        ph  = PH_DOWN;
                    end else begin
                        // compare at 9 bits so a counter at 255 still ends the burst
                        next_cnt = {1'b0, step_cnt} + 9'd1;
                        if (next_cnt < {1'b0, cfg.flash_count}) begin
                            step_cnt = next_cnt[7:0];
                            ph       = PH_UP;
                        end else begin
                            step_cnt = 8'd0;
                            ph       = PH_PAUSE;
                        end
                    end
                end else if (elapsed > 32'(cfg.end_pause_ms) && ph >= PH_PAUSE) begin
                    ph = PH_UP;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------

    // Call at a falling edge; returns at the falling edge after the accept
    task automatic send_word(logic op, logic [31:0] now, bit has_want, t_result want);
        t_result pred;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_now_ms   <= now;
        do
            @(posedge i_clk);
        while (!(i_in_valid && !o_in_stall));
        pred = predict_strip(op, now);
        strip_colors_q.push_back(has_want ? want : pred);
        @(negedge i_clk);
    endtask

    // Setup cycle, access cycle, then idle
    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        case (idx)
            REG_EFFECT_MODE:    cfg.effect_mode    = val[1:0];
            REG_COLOR_RED:      cfg.color_red      = val[7:0];
            REG_COLOR_GREEN:    cfg.color_green    = val[7:0];
            REG_COLOR_BLUE:     cfg.color_blue     = val[7:0];
            REG_FLASH_COUNT:    cfg.flash_count    = val[7:0];
            REG_FLASH_DELAY_MS: cfg.flash_delay_ms = val[15:0];
            REG_END_PAUSE_MS:   cfg.end_pause_ms   = val[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every expected word has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (strip_colors_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic add_word(logic op, logic [31:0] now, bit has_want, t_result want);
        dir_rows.push_back('{ROW_WORD, op, 3'd0, now, has_want, want});
    endtask

    task automatic add_cfg(logic [2:0] idx, logic [31:0] val);
        dir_rows.push_back('{ROW_CFG, OP_TICK, idx, val, 1'b0, NO_UPDATE});
    endtask

    // Extremes for half the picks, otherwise any byte
    function automatic logic [7:0] pick_color();
        case ($urandom_range(3))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_gap();
        case ($urandom_range(5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 40));
        endcase
    endfunction

    // Time step that lands around whichever threshold matters next
    function automatic logic [31:0] next_gap();
        logic [31:0] thr;
        if (cfg.effect_mode != MODE_STROBE)
            thr = RGB_LOOP_GAP_MS;
        else if (ph >= PH_PAUSE)
            thr = 32'(cfg.end_pause_ms);
        else
            thr = 32'(cfg.flash_delay_ms);
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return thr;
            2:       return thr + 32'd1;
            default: return $urandom_range(0, 2 * thr + 2);
        endcase
    endfunction

    // Receiver back-pressure
    always @(negedge i_clk)
        i_out_stall <= ($urandom_range(99) < stall_pct);

    // ---------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------
    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (strip_colors_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word, expected none, got update %0d rgb %0d %0d %0d",
                         $time, o_strip_update, o_out_red, o_out_green, o_out_blue);
            end else begin
                want = strip_colors_q.pop_front();
                check_field("strip_update", {7'd0, want.strip_update}, {7'd0, o_strip_update});
                check_field("out_red", want.out_red, o_out_red);
                check_field("out_green", want.out_green, o_out_green);
                check_field("out_blue", want.out_blue, o_out_blue);
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin : stimulus
        logic [1:0]  mode;
        logic [31:0] cur_ms;
        logic        op;
        int          n_words;
        int          restart_pct;
        bit          long_burst;

        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_in_valid    = 1'b0;
        i_opcode      = OP_TICK;
        i_now_ms      = '0;
        mismatches    = 0;
        send_idle_pct = 37;
        stall_pct     = 66;

        cfg = '{RST_EFFECT_MODE, RST_COLOR, RST_COLOR, RST_COLOR, RST_FLASH_COUNT,
                RST_FLASH_DELAY_MS, RST_END_PAUSE_MS};
        pending  = 1'b1;
        step_cnt = 8'd0;
        lvl      = 8'd0;
        ph       = PH_UP;
        last_ms  = 32'd0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // rgb loop straight out of reset: gap must exceed 3 ms, wraps included
        add_word(OP_TICK, 32'd0, 1, NO_UPDATE);
        add_word(OP_TICK, 32'd3, 1, NO_UPDATE);
        add_word(OP_TICK, 32'd4, 1, '{1'b1, 8'd0, 8'd0, 8'd0});
        add_word(OP_TICK, 32'hFFFF_FFFF, 1, '{1'b1, 8'd1, 8'd0, 8'd0});
        add_word(OP_TICK, 32'd2, 1, NO_UPDATE);
        add_word(OP_TICK, 32'd3, 1, '{1'b1, 8'd2, 8'd0, 8'd0});
        add_word(OP_RESTART, 32'hAAAA_5555, 1, NO_UPDATE);
        add_word(OP_TICK, 32'h5555_AAAA, 1, '{1'b1, 8'd0, 8'd0, 8'd0});
        // fade with color extremes
        add_cfg(REG_EFFECT_MODE, 32'(MODE_FADE));
        add_cfg(REG_COLOR_RED, 32'd0);
        add_cfg(REG_COLOR_GREEN, 32'd128);
        add_cfg(REG_COLOR_BLUE, 32'd255);
        add_word(OP_RESTART, 32'd0, 1, NO_UPDATE);
        add_word(OP_TICK, 32'd0, 1, '{1'b1, 8'd0, 8'd0, 8'd0});
        add_word(OP_TICK, 32'd1, 0, NO_UPDATE);
        // strobe with zero count, zero delay and zero pause; a zero count
        // still shows one flash before the end pause
        add_cfg(REG_EFFECT_MODE, 32'(MODE_STROBE));
        add_cfg(REG_FLASH_COUNT, 32'd0);
        add_cfg(REG_FLASH_DELAY_MS, 32'd0);
        add_cfg(REG_END_PAUSE_MS, 32'd0);
        add_word(OP_RESTART, 32'd0, 1, NO_UPDATE);
        add_word(OP_TICK, 32'd0, 1, '{1'b1, 8'd0, 8'd128, 8'd255});
        add_word(OP_TICK, 32'd0, 1, NO_UPDATE);
        add_word(OP_TICK, 32'd1, 1, '{1'b1, 8'd0, 8'd0, 8'd0});
        add_word(OP_TICK, 32'd1, 1, NO_UPDATE);
        add_word(OP_TICK, 32'd2, 1, NO_UPDATE);
        add_word(OP_TICK, 32'd2, 1, '{1'b1, 8'd0, 8'd128, 8'd255});
        // unused mode code leaves the strip alone
        add_cfg(REG_EFFECT_MODE, 32'(MODE_OFF));
        add_word(OP_TICK, 32'h1234_5678, 1, NO_UPDATE);
        add_word(OP_RESTART, 32'd0, 1, NO_UPDATE);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                drain();
                cfg_write(dir_rows[i].reg_idx, dir_rows[i].value);
            end else begin
                send_word(dir_rows[i].op, dir_rows[i].value, dir_rows[i].has_want,
                          dir_rows[i].want);
            end
        end

        // Random phases: modes cycle, idling swaps every four phases, then stops.
        // Phase 10 runs one long strobe burst of 255 flashes to reach the top
        // of the flash counter; state carries over between phases on purpose.
        cur_ms = 32'h5555_AAAA;
        for (int p = 0; p < 12; p++) begin
            case (p / 4)
                0: begin send_idle_pct = 37; stall_pct = 66; end
                1: begin send_idle_pct = 66; stall_pct = 37; end
                default: begin send_idle_pct = 0; stall_pct = 0; end
            endcase
            drain();
            mode       = 2'(p % 4);
            long_burst = (p == 10);
            cfg_write(REG_EFFECT_MODE, 32'(mode));
            cfg_write(REG_COLOR_RED, 32'(pick_color()));
            cfg_write(REG_COLOR_GREEN, 32'(pick_color()));
            cfg_write(REG_COLOR_BLUE, 32'(pick_color()));
            case ($urandom_range(3))
                0:       cfg_write(REG_FLASH_COUNT, long_burst ? 32'd255 : 32'd0);
                1:       cfg_write(REG_FLASH_COUNT, long_burst ? 32'd255 : 32'd1);
                default: cfg_write(REG_FLASH_COUNT,
                                   long_burst ? 32'd255 : 32'($urandom_range(2, 12)));
            endcase
            cfg_write(REG_FLASH_DELAY_MS, long_burst ? 32'd0 : 32'(pick_gap()));
            cfg_write(REG_END_PAUSE_MS, 32'(pick_gap()));

            if (mode == MODE_OFF)
                n_words = 30;
            else if (long_burst)
                n_words = 800;
            else if (mode == MODE_FADE)
                n_words = 170;
            else
                n_words = 130;
            restart_pct = long_burst ? 0 : (mode == MODE_STROBE ? 4 : 1);
            // start some phases just below the 32-bit wrap
            if (p % 3 == 0)
                cur_ms = 32'hFFFF_FFF0;

            for (int n = 0; n < n_words; n++) begin
                op     = ($urandom_range(99) < restart_pct) ? OP_RESTART : OP_TICK;
                cur_ms = cur_ms + next_gap();
                send_word(op, cur_ms, 1'b0, NO_UPDATE);
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
hdl/lces_pkg.sv
hdl/lces_cfg.sv
hdl/lces_core.sv
hdl/lces_obuf.sv
hdl/led_color_effect_sequencer_top.sv
bench/tb_led_color_effect_sequencer_top.sv
